FILE: sv/cyclic_piecewise_waveform_unit_macros.svh
// Assertion macros shared by the waveform unit RTL.
`ifndef CYCLIC_PIECEWISE_WAVEFORM_UNIT_MACROS_SVH
`define CYCLIC_PIECEWISE_WAVEFORM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPW_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPW_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPW_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/cpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cpw_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int SEG_W        = 5;
    localparam int END_AW       = 6;
    localparam int TIME_W       = 32;
    localparam int LVL_W        = 24;
    localparam int DUR_W        = 24;
    localparam int PD_W         = 17;
    localparam int CNT_W        = 6;
    localparam int DIV_W        = 56;
    localparam int DIV_CNT_W    = 6;

    typedef enum logic [1:0] {
        REG_SEG_COUNT   = 2'd0,
        REG_PHASE_DELAY = 2'd1,
        REG_INTERP_EN   = 2'd2
    } t_reg_idx;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CYC, S_OFS, S_MOD, S_L1, S_L2, S_BSA, S_BSB, S_BSC,
        S_F0, S_F1, S_F2, S_SUB, S_MUL, S_DVS
    } t_state;

    typedef struct packed {
        logic [END_AW-1:0] end_raddr;
        logic              end_we;
        logic [END_AW-1:0] end_waddr;
        logic [TIME_W-1:0] end_wdata;
        logic [SEG_W-1:0]  lvl_raddr;
        logic              lvl_we;
        logic [SEG_W-1:0]  lvl_waddr;
        logic [LVL_W-1:0]  lvl_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [TIME_W-1:0] end_rdata;
        logic [LVL_W-1:0]  lvl_rdata;
    } t_mem_rsp;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [TIME_W-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

FILE: sv/cpw_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module cpw_mem import cpw_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_mem_rsp      o_rsp
);
    // end time 0 is fixed at zero and not stored
    logic [TIME_W-1:0] r_end_mem [1:MAX_SEGMENTS];
    logic [LVL_W-1:0]  r_lvl_mem [0:MAX_SEGMENTS-1];
    logic [TIME_W-1:0] r_end_q;
    logic [LVL_W-1:0]  r_lvl_q;
    logic              r_end_zero;

    always_ff @(posedge i_clk) begin
        if (i_req.end_we) begin
            r_end_mem[i_req.end_waddr] <= i_req.end_wdata;
        end
        if (i_req.end_raddr != '0) begin
            r_end_q <= r_end_mem[i_req.end_raddr];
        end
        r_end_zero <= (i_req.end_raddr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lvl_we) begin
            r_lvl_mem[i_req.lvl_waddr] <= i_req.lvl_wdata;
        end
        r_lvl_q <= r_lvl_mem[i_req.lvl_raddr];
    end

    assign o_rsp.end_rdata = r_end_zero ? '0 : r_end_q;
    assign o_rsp.lvl_rdata = r_lvl_q;
endmodule
`default_nettype wire

FILE: sv/cpw_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cyclic_piecewise_waveform_unit_macros.svh"
module cpw_div import cpw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    // restoring divider, one quotient bit per cycle
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_q;
    logic [TIME_W-1:0]    r_r;
    logic [TIME_W-1:0]    r_dvs;
    logic [TIME_W:0]      shifted;
    logic                 fits;

    assign shifted = {r_r, r_q[DIV_W-1]};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_r   <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_W-2:0], fits};
            r_r <= fits ? TIME_W'(shifted - {1'b0, r_dvs}) : shifted[TIME_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r;

    `CPW_ASSERT(a_div_start_idle, i_clk, i_rst_n, i_req.start |-> !r_busy, "divider restarted while busy")
    `CPW_ASSERT(a_div_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "divider done without run")
    `CPW_ASSERT(a_div_busy_not_done, i_clk, i_rst_n, r_busy |-> !r_done, "divider done while busy")
endmodule
`default_nettype wire

FILE: sv/cyclic_piecewise_waveform_unit.sv
// Load transaction: read previous end time, then write end time and level.
// Evaluate transaction: the time from accept to o_valid is set by the 56-step serial
// divider (modulo, then a second pass for the blend) and by the end-time reads in the
// segment search. An empty cycle skips both.
// One transaction in flight at a time. Reset: synchronous, count 1, phase 0, stepped mode;
// end time 0 reads as zero, other table entries hold garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "cyclic_piecewise_waveform_unit_macros.svh"
module cyclic_piecewise_waveform_unit import cpw_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_func,
    input  wire logic [SEG_W-1:0]         i_seg_index,
    input  wire logic [DUR_W-1:0]         i_seg_duration,
    input  wire logic signed [LVL_W-1:0]  i_seg_level,
    input  wire logic [TIME_W-1:0]        i_sample_time,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [LVL_W-1:0]       o_out_level,
    output logic [SEG_W-1:0]              o_out_segment,
    output logic                          o_status,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [3:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    t_state r_state, n_state;
    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [CNT_W-1:0]  r_seg_cnt;
    logic [PD_W-1:0]   r_pd;
    logic              r_interp;

    logic [SEG_W-1:0]  r_idx, n_idx;
    logic [DUR_W-1:0]  r_dur, n_dur;
    logic [LVL_W-1:0]  r_lvl_in, n_lvl_in;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] r_cycle, n_cycle;
    logic [48:0]       r_prod, n_prod;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic [SEG_W-1:0]  r_mid, n_mid;
    logic [SEG_W-1:0]  r_k, n_k;
    logic [SEG_W-1:0]  r_last, n_last;
    logic [TIME_W-1:0] r_e0, n_e0, r_e1, n_e1;
    logic [LVL_W-1:0]  r_a, n_a, r_b, n_b;
    logic [TIME_W-1:0] r_dt, n_dt, r_dw, n_dw;
    logic [LVL_W-1:0]  r_dmag, n_dmag;
    logic              r_neg, n_neg;
    logic [DIV_W-1:0]  r_num, n_num;
    logic [LVL_W-1:0]  r_res_level, n_res_level;
    logic [SEG_W-1:0]  r_res_seg, n_res_seg;
    logic              r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [LVL_W-1:0]  r_out_level, n_out_level;
    logic [SEG_W-1:0]  r_out_seg, n_out_seg;
    logic              r_out_status, n_out_status;

    logic [CNT_W-1:0]  cnt_eff;
    logic [PD_W-1:0]   pd_eff;
    logic [TIME_W-1:0] offset;
    logic [TIME_W:0]   phased;
    logic [TIME_W:0]   ld_sum;
    logic [CNT_W:0]    lo_hi;
    logic [LVL_W:0]    diff;
    logic [LVL_W-1:0]  quo;
    logic [CNT_W-1:0]  k_next;
    logic              in_acc;
    logic              cfg_we;

    logic              r_div_run;
    logic              r_div_pend;
    logic              r_res_ready;
    logic              dvs_start;
    logic [LVL_W-1:0]  interp_level;
    logic              out_free;
    logic [LVL_W-1:0]  r_fin_level;
    t_state            st_q;
    t_div_req          div_req_q;

    cpw_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    cpw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req_q),
        .o_rsp   (div_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_cnt <= CNT_W'(1);
            r_pd      <= '0;
            r_interp  <= 1'b0;
        end else if (cfg_we) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_SEG_COUNT:   r_seg_cnt <= pwdata[CNT_W-1:0];
                REG_PHASE_DELAY: r_pd      <= pwdata[PD_W-1:0];
                REG_INTERP_EN:   r_interp  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_SEG_COUNT:   prdata = 32'(r_seg_cnt);
            REG_PHASE_DELAY: prdata = 32'(r_pd);
            REG_INTERP_EN:   prdata = 32'(r_interp);
            default:         prdata = '0;
        endcase
    end

    assign cnt_eff = (r_seg_cnt == '0) ? CNT_W'(1) :
                     (r_seg_cnt > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : r_seg_cnt;
    assign pd_eff  = (r_pd > PD_W'(65536)) ? PD_W'(65536) : r_pd;
    assign offset  = r_cycle - r_prod[47:16];
    assign phased  = {1'b0, r_time} + {1'b0, offset};
    assign ld_sum  = {1'b0, mem_rsp.end_rdata} + (TIME_W+1)'(r_dur);
    assign lo_hi   = {1'b0, r_lo} + {1'b0, r_hi};
    assign diff    = {r_b[LVL_W-1], r_b} - {r_a[LVL_W-1], r_a};
    assign quo     = div_rsp.quo[LVL_W-1:0];
    assign k_next  = {1'b0, r_k} + CNT_W'(1);

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_dur        = r_dur;
        n_lvl_in     = r_lvl_in;
        n_time       = r_time;
        n_cycle      = r_cycle;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_k          = r_k;
        n_last       = r_last;
        n_e0         = r_e0;
        n_e1         = r_e1;
        n_a          = r_a;
        n_b          = r_b;
        n_dt         = r_dt;
        n_dw         = r_dw;
        n_dmag       = r_dmag;
        n_neg        = r_neg;
        n_num        = r_num;
        n_res_level  = r_res_level;
        n_res_seg    = r_res_seg;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_level  = r_out_level;
        n_out_seg    = r_out_seg;
        n_out_status = r_out_status;
        mem_req      = '0;
        div_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_LOAD) begin
                        n_idx             = i_seg_index;
                        n_dur             = i_seg_duration;
                        n_lvl_in          = i_seg_level;
                        mem_req.end_raddr = END_AW'(i_seg_index);
                        n_state           = S_LOAD;
                    end else begin
                        n_time            = i_sample_time;
                        mem_req.end_raddr = cnt_eff;
                        n_state           = S_CYC;
                    end
                end
            end
            S_LOAD: begin
                mem_req.end_we    = 1'b1;
                mem_req.end_waddr = END_AW'(r_idx) + END_AW'(1);
                mem_req.end_wdata = ld_sum[TIME_W] ? '1 : ld_sum[TIME_W-1:0];
                mem_req.lvl_we    = 1'b1;
                mem_req.lvl_waddr = r_idx;
                mem_req.lvl_wdata = r_lvl_in;
                n_state           = S_IDLE;
            end
            S_CYC: begin
                n_cycle = mem_rsp.end_rdata;
                n_prod  = mem_rsp.end_rdata * pd_eff;
                if (mem_rsp.end_rdata == '0) begin
                    // empty cycle: forced level, search state untouched
                    n_res_level  = '0;
                    n_res_seg    = '0;
                    n_res_status = 1'b1;
                    n_state      = S_DVS;
                    n_num        = '0;
                end else begin
                    n_state = S_OFS;
                end
            end
            S_OFS: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(phased);
                div_req.divisor  = r_cycle;
                n_state          = S_MOD;
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    n_rem = div_rsp.rem;
                    if ({1'b0, r_last} < cnt_eff) begin
                        mem_req.end_raddr = END_AW'(r_last);
                        n_state           = S_L1;
                    end else begin
                        n_lo    = '0;
                        n_hi    = cnt_eff;
                        n_state = S_BSA;
                    end
                end
            end
            S_L1: begin
                n_e0              = mem_rsp.end_rdata;
                mem_req.end_raddr = END_AW'(r_last) + END_AW'(1);
                n_state           = S_L2;
            end
            S_L2: begin
                if (r_e0 <= r_rem && mem_rsp.end_rdata > r_rem) begin
                    n_k     = r_last;
                    n_state = S_F0;
                end else begin
                    n_lo    = '0;
                    n_hi    = cnt_eff;
                    n_state = S_BSA;
                end
            end
            S_BSA: begin
                if (r_lo >= r_hi) begin
                    n_k     = '0;
                    n_state = S_F0;
                end else begin
                    n_mid             = lo_hi[SEG_W:1];
                    mem_req.end_raddr = END_AW'(lo_hi[SEG_W:1]);
                    n_state           = S_BSB;
                end
            end
            S_BSB: begin
                if (r_rem < mem_rsp.end_rdata) begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = S_BSA;
                end else begin
                    mem_req.end_raddr = END_AW'(r_mid) + END_AW'(1);
                    n_state           = S_BSC;
                end
            end
            S_BSC: begin
                if (r_rem >= mem_rsp.end_rdata) begin
                    n_lo    = CNT_W'(r_mid) + CNT_W'(1);
                    n_state = S_BSA;
                end else begin
                    n_k     = r_mid;
                    n_state = S_F0;
                end
            end
            S_F0: begin
                n_last            = r_k;
                mem_req.end_raddr = END_AW'(r_k);
                mem_req.lvl_raddr = r_k;
                n_state           = S_F1;
            end
            S_F1: begin
                n_e0              = mem_rsp.end_rdata;
                n_a               = mem_rsp.lvl_rdata;
                mem_req.end_raddr = END_AW'(k_next);
                // last segment blends toward segment 0
                mem_req.lvl_raddr = (k_next == cnt_eff) ? '0 : k_next[SEG_W-1:0];
                n_state           = S_F2;
            end
            S_F2: begin
                n_e1    = mem_rsp.end_rdata;
                n_b     = mem_rsp.lvl_rdata;
                n_state = S_SUB;
            end
            S_SUB: begin
                n_dt   = r_rem - r_e0;
                n_dw   = r_e1 - r_e0;
                n_neg  = diff[LVL_W];
                n_dmag = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
                n_res_seg    = r_k;
                n_res_status = 1'b0;
                if (r_interp && r_e1 > r_e0 && r_rem >= r_e0) begin
                    n_state = S_MUL;
                end else begin
                    n_res_level = r_a;
                    n_num       = '0;
                    n_state     = S_DVS;
                end
            end
            S_MUL: begin
                n_num            = r_dt * r_dmag;
                div_req.start    = 1'b0;
                n_res_level      = '1;
                n_state          = S_DVS;
            end
            S_DVS: begin
                n_state = S_DVS;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // interpolation divide and result handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run   <= 1'b0;
            r_div_pend  <= 1'b0;
            r_res_ready <= 1'b0;
        end else begin
            if (r_state == S_MUL) begin
                r_div_pend <= 1'b1;
            end else if (r_div_pend) begin
                r_div_pend <= 1'b0;
                r_div_run  <= 1'b1;
            end
            if (r_state != S_DVS) begin
                r_res_ready <= 1'b0;
            end else if (!r_div_pend && !r_div_run) begin
                r_res_ready <= 1'b1;
            end else if (r_div_run && div_rsp.done) begin
                r_div_run   <= 1'b0;
                r_res_ready <= 1'b1;
            end
        end
    end

    assign dvs_start    = r_div_pend;
    assign interp_level = r_a + (r_neg ? LVL_W'(-quo) : quo);
    assign out_free     = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (r_div_run && div_rsp.done) begin
            r_fin_level <= interp_level;
        end else if (r_state == S_DVS && !r_div_pend && !r_div_run && !r_res_ready) begin
            r_fin_level <= r_res_level;
        end
    end

    always_comb begin
        st_q = n_state;
        if (r_state == S_DVS) begin
            st_q = (r_res_ready && out_free) ? S_IDLE : S_DVS;
        end
    end

    always_comb begin
        div_req_q = div_req;
        if (dvs_start) begin
            div_req_q.start    = 1'b1;
            div_req_q.dividend = r_num;
            div_req_q.divisor  = r_dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
            r_res_status <= 1'b0;
        end else begin
            r_state      <= st_q;
            r_last       <= n_last;
            r_res_status <= n_res_status;
            if (r_state == S_DVS && r_res_ready && out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= n_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_dur       <= n_dur;
        r_lvl_in    <= n_lvl_in;
        r_time      <= n_time;
        r_cycle     <= n_cycle;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_k         <= n_k;
        r_e0        <= n_e0;
        r_e1        <= n_e1;
        r_a         <= n_a;
        r_b         <= n_b;
        r_dt        <= n_dt;
        r_dw        <= n_dw;
        r_dmag      <= n_dmag;
        r_neg       <= n_neg;
        r_num       <= n_num;
        r_res_level <= n_res_level;
        r_res_seg   <= n_res_seg;
        if (r_state == S_DVS && r_res_ready && out_free) begin
            r_out_level  <= r_fin_level;
            r_out_seg    <= r_res_seg;
            r_out_status <= r_res_status;
        end else begin
            r_out_level  <= n_out_level;
            r_out_seg    <= n_out_seg;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_level   = r_out_level;
    assign o_out_segment = r_out_seg;
    assign o_status      = r_out_status;

    `CPW_ASSERT(a_out_from_final, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_DVS, "result without finish")
    `CPW_ASSERT(a_status_forced, i_clk, i_rst_n, (r_out_valid && r_out_status) |-> (r_out_level == '0 && r_out_seg == '0), "forced result not zero")
    `CPW_ASSERT(a_last_from_fetch, i_clk, i_rst_n, ($past(i_rst_n) && !$stable(r_last)) |-> $past(r_state) == S_F0, "last segment changed outside fetch")
endmodule
`default_nettype wire

FILE: sim/cyclic_piecewise_waveform_unit_tb.sv
`timescale 1ns / 1ps
module cyclic_piecewise_waveform_unit_tb;
    import cpw_pkg::*;

    typedef struct {
        t_func                    func;
        logic [SEG_W-1:0]         idx;
        logic [DUR_W-1:0]         dur;
        logic signed [LVL_W-1:0]  lvl;
        logic [TIME_W-1:0]        t;
    } t_wave_op;

    typedef struct {
        logic signed [LVL_W-1:0]  lvl;
        logic [SEG_W-1:0]         seg;
        logic                     status;
    } t_wave_out;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_func = 1'b0;
    logic [SEG_W-1:0]         i_seg_index = '0;
    logic [DUR_W-1:0]         i_seg_duration = '0;
    logic signed [LVL_W-1:0]  i_seg_level = '0;
    logic [TIME_W-1:0]        i_sample_time = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [LVL_W-1:0]  o_out_level;
    logic [SEG_W-1:0]         o_out_segment;
    logic                     o_status;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [3:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    cyclic_piecewise_waveform_unit u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [TIME_W-1:0]        seg_end_q [0:MAX_SEGMENTS];
    logic signed [LVL_W-1:0]  seg_lvl_q [0:MAX_SEGMENTS];
    logic [SEG_W-1:0]         last_seg_q;
    logic [CNT_W-1:0]         seg_count_q;
    logic [PD_W-1:0]          phase_q;
    logic                     interp_q;

    t_wave_op   pending_ops[$];
    t_wave_out  expected_outs[$];
    int         n_errors = 0;
    int         n_loads = 0, n_evals = 0, n_results = 0, n_zero_cycle = 0;
    bit         op_taken = 0;
    bit         hold_req = 0;
    int         plan_top = 0;   // ends 1..plan_top and levels 0..plan_top-1 are loaded
    int         plan_count = 1;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic void apply_waveform_op(input t_wave_op op);
        int unsigned              n, k, lo, hi, mid;
        logic [63:0]              cyc, pd, ofs, sum;
        logic [31:0]              rem;
        longint                   a, b, lvl;
        bit                       hit;
        t_wave_out                r;
        if (op.func == FUNC_LOAD) begin
            sum = {32'd0, seg_end_q[op.idx]} + {40'd0, op.dur};
            seg_end_q[op.idx + 1] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            seg_lvl_q[op.idx] = op.lvl;
            n_loads++;
            return;
        end
        n_evals++;
        n = seg_count_q;
        if (n < 1) n = 1;
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        cyc = {32'd0, seg_end_q[n]};
        if (cyc == 0) begin
            r.lvl = '0; r.seg = '0; r.status = 1'b1;
            n_zero_cycle++;
            expected_outs.push_back(r);
            return;
        end
        pd = (phase_q > 17'd65536) ? 64'd65536 : {47'd0, phase_q};
        ofs = cyc - ((cyc * pd) >> 16);
        sum = ({32'd0, op.t} + ofs) % cyc;
        rem = sum[31:0];
        hit = 0;
        k = 0;
        if (last_seg_q < n && seg_end_q[last_seg_q] <= rem && seg_end_q[last_seg_q + 1] > rem) begin
            k = last_seg_q;
            hit = 1;
        end
        lo = 0;
        hi = n;
        while (!hit && lo < hi) begin
            mid = (lo + hi) / 2;
            if (rem < seg_end_q[mid]) hi = mid;
            else if (rem >= seg_end_q[mid + 1]) lo = mid + 1;
            else begin
                k = mid;
                hit = 1;
            end
        end
        last_seg_q = k[SEG_W-1:0];
        a = seg_lvl_q[k];
        lvl = a;
        if (interp_q) begin
            b = (k + 1 == n) ? longint'(seg_lvl_q[0]) : longint'(seg_lvl_q[k + 1]);
            if (seg_end_q[k + 1] > seg_end_q[k] && rem >= seg_end_q[k])
                lvl = a + (longint'(rem - seg_end_q[k]) * (b - a)) /
                      longint'(seg_end_q[k + 1] - seg_end_q[k]);
        end
        r.lvl = lvl[LVL_W-1:0];
        r.seg = k[SEG_W-1:0];
        r.status = 1'b0;
        expected_outs.push_back(r);
    endfunction

    // input side: acceptance at the rising edge, driving at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            t_wave_op op;
            op.func = t_func'(i_func);
            op.idx = i_seg_index;
            op.dur = i_seg_duration;
            op.lvl = i_seg_level;
            op.t = i_sample_time;
            apply_waveform_op(op);
            op_taken = 1;
        end
    end

    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || op_taken)) begin
            op_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                t_wave_op op;
                op = pending_ops.pop_front();
                i_func <= op.func;
                i_seg_index <= op.idx;
                i_seg_duration <= op.dur;
                i_seg_level <= op.lvl;
                i_sample_time <= op.t;
                i_valid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side stall pattern, plus one long hold-off on request
    int hold_left = 0, stall_mode = 0, mode_left = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 3000;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 800);
        end else mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            default: i_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_wave_out want;
            n_results++;
            if (expected_outs.size() == 0) begin
                report_mismatch("unexpected result, segment", o_out_segment, -1);
            end else begin
                want = expected_outs.pop_front();
                if (o_out_level !== want.lvl) report_mismatch("out_level", o_out_level, want.lvl);
                if (o_out_segment !== want.seg)
                    report_mismatch("out_segment", o_out_segment, want.seg);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    task automatic reg_write(input t_reg_idx ridx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {ridx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (ridx)
            REG_SEG_COUNT:   seg_count_q = val[CNT_W-1:0];
            REG_PHASE_DELAY: phase_q = val[PD_W-1:0];
            default:         interp_q = val[0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_ops.size() > 0 || i_valid || expected_outs.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_mode(input int cnt, input int pd, input bit ip);
        reg_write(REG_SEG_COUNT, cnt);
        reg_write(REG_PHASE_DELAY, pd);
        reg_write(REG_INTERP_EN, 32'(ip));
        plan_count = (cnt < 1) ? 1 : (cnt > MAX_SEGMENTS) ? MAX_SEGMENTS : cnt;
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {DUR_W{1'b1}};
            2: return DUR_W'($urandom_range(1000, 16777215));
            default: return DUR_W'($urandom_range(1, 200));
        endcase
    endfunction

    function automatic logic signed [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            default: return LVL_W'($urandom);
        endcase
    endfunction

    task automatic push_load(input int idx, input logic [DUR_W-1:0] d,
                             input logic signed [LVL_W-1:0] l);
        t_wave_op op;
        op.func = FUNC_LOAD;
        op.idx = SEG_W'(idx);
        op.dur = d;
        op.lvl = l;
        op.t = $urandom;
        pending_ops.push_back(op);
        if (idx + 1 > plan_top) plan_top = idx + 1;
    endtask

    task automatic push_eval(input logic [TIME_W-1:0] t);
        t_wave_op op;
        op.func = FUNC_EVAL;
        op.idx = SEG_W'($urandom);
        op.dur = DUR_W'($urandom);
        op.lvl = LVL_W'($urandom);
        op.t = t;
        pending_ops.push_back(op);
    endtask

    // well-formed table for the active count, then mostly samples with some reloads
    task automatic run_phase(input int n_ops);
        for (int k = 0; k < plan_count; k++) push_load(k, pick_duration(), pick_level());
        for (int j = 0; j < n_ops; j++) begin
            if ($urandom_range(0, 9) == 0)
                push_load($urandom_range(0, (plan_top > 31) ? 31 : plan_top),
                          pick_duration(), pick_level());
            else
                push_eval(($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : $urandom);
        end
        wait_drained();
    endtask

    initial begin
        seg_end_q[0] = '0;
        last_seg_q = '0;
        seg_count_q = CNT_W'(1);
        phase_q = '0;
        interp_q = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length cycle, then extremes of duration, level and time
        push_load(0, '0, 24'sh7FFFFF);
        push_eval('0);
        push_eval(32'hFFFF_FFFF);
        wait_drained();
        set_mode(0, 0, 1);
        push_eval(32'd5);
        push_load(0, {DUR_W{1'b1}}, 24'sh800000);
        push_eval('0);
        push_eval(32'hFFFF_FFFF);
        wait_drained();
        // zero-width middle segment, wrap of the last segment, phase above one
        set_mode(3, 131071, 1);
        push_load(1, '0, 24'sh7FFFFF);
        push_load(2, 24'd10, 24'sh000100);
        for (int t = 0; t < 8; t++) push_eval($urandom_range(0, 32'd16777230));
        push_eval(32'd16777215);
        push_eval(32'd16777220);
        wait_drained();
        set_mode(63, 65536, 0);
        for (int k = 0; k < MAX_SEGMENTS; k++)
            push_load(k, DUR_W'($urandom_range(0, 20)), pick_level());
        push_eval('0);
        push_eval(32'hFFFF_FFFF);
        wait_drained();

        set_mode(4, 32768, 1);
        hold_req = 1;
        run_phase(60);
        for (int p = 0; p < 10; p++) begin
            set_mode(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(65536, 131071)
                                                 : $urandom_range(0, 65536),
                     $urandom_range(0, 1));
            run_phase(60);
        end
        set_mode(1, 0, 0);

        $display("Covered %0d segment loads and %0d evaluations, %0d results checked",
                 n_loads, n_evals, n_results);
        $display("(%0d zero-length cycles); stepped and interpolated modes, phases 0..max",
                 n_zero_cycle);
        if (n_errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timeout waiting for transactions to drain");
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/cpw_pkg.sv
sv/cpw_mem.sv
sv/cpw_div.sv
sv/cyclic_piecewise_waveform_unit.sv
sim/cyclic_piecewise_waveform_unit_tb.sv
